>>> rtl/systematic_binary_group_code_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the group code encoder
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SYSTEMATIC_BINARY_GROUP_CODE_ENCODER_TOP_DEFINES_SVH
`define SYSTEMATIC_BINARY_GROUP_CODE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication
`define SBGC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SBGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sbgc_pkg.sv
// ----------------------------------------------------------------------------
// sbgc_pkg
// Types and constants shared by the group code encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbgc_pkg;

    // Width of one parity matrix row and of the message field
    localparam int ROW_BITS = 8;
    // Codeword field width
    localparam int CW_BITS  = 16;
    // Codeword weight width (0..CW_BITS)
    localparam int WT_BITS  = 5;
    // Detectable error count width
    localparam int DET_BITS = 4;
    // Length register width
    localparam int LEN_BITS = 4;
    // Configuration index width
    localparam int IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_MESSAGE_LENGTH = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_PARITY_LENGTH  = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_PARITY_MATRIX  = 2'd2;

    // Request kinds carried in tuser
    localparam logic FUNC_ENCODE  = 1'b0;
    localparam logic FUNC_ANALYZE = 1'b1;

    typedef logic [ROW_BITS-1:0] t_row;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Result of the shared encode and weight unit
    typedef struct packed {
        logic [CW_BITS-1:0] codeword;
        logic [WT_BITS-1:0] weight;
    } t_enc_res;

endpackage

`default_nettype wire

>>> rtl/sbgc_enc.sv
// ----------------------------------------------------------------------------
// sbgc_enc
// Shared encode unit: forms the systematic codeword of one message and its
// Hamming weight.
// ----------------------------------------------------------------------------
`default_nettype none

module sbgc_enc (
    input  wire logic [sbgc_pkg::ROW_BITS-1:0]       i_msg,
    input  wire logic [sbgc_pkg::LEN_BITS-1:0]       i_m_len,   // 1..ROW_BITS
    input  wire logic [sbgc_pkg::LEN_BITS-1:0]       i_r_len,   // 0..ROW_BITS
    input  wire logic [sbgc_pkg::ROW_BITS*sbgc_pkg::ROW_BITS-1:0] i_matrix,
    output sbgc_pkg::t_enc_res                      o_res
);

    localparam int RB = sbgc_pkg::ROW_BITS;
    localparam int RW = $clog2(sbgc_pkg::ROW_BITS);

    sbgc_pkg::t_row                     w_rows [RB];
    logic [RB-1:0]                      w_msg;
    logic [RB-1:0]                      w_acc;
    logic [RB-1:0]                      w_acc_m;
    logic [RB-1:0]                      w_rev;
    logic [RB-1:0]                      w_par;
    logic [RW-1:0]                      w_ridx [RB];
    logic [sbgc_pkg::CW_BITS-1:0]       w_cw;

    always_comb begin
        for (int k = 0; k < RB; k++) begin
            w_rows[k] = i_matrix[k*RB +: RB];
        end
    end

    // Message bit j belongs to row m-1-j (rows count from the first bit)
    always_comb begin
        w_msg = i_msg & ({RB{1'b1}} >> (sbgc_pkg::LEN_BITS'(RB) - i_m_len));
        w_acc = '0;
        for (int j = 0; j < RB; j++) begin
            w_ridx[j] = RW'(i_m_len - sbgc_pkg::LEN_BITS'(j) - 4'd1);
            if ((sbgc_pkg::LEN_BITS'(j) < i_m_len) && w_msg[j]) begin
                w_acc = w_acc ^ w_rows[w_ridx[j]];
            end
        end
    end

    // Column c lands at codeword bit r-1-c
    always_comb begin
        w_acc_m = w_acc & ({RB{1'b1}} >> (sbgc_pkg::LEN_BITS'(RB) - i_r_len));
        for (int c = 0; c < RB; c++) begin
            w_rev[RB-1-c] = w_acc_m[c];
        end
        w_par = w_rev >> (sbgc_pkg::LEN_BITS'(RB) - i_r_len);
        w_cw  = (sbgc_pkg::CW_BITS'(w_msg) << i_r_len) | sbgc_pkg::CW_BITS'(w_par);
    end

    assign o_res.codeword = w_cw;
    assign o_res.weight   = sbgc_pkg::WT_BITS'($countones(w_cw));

endmodule

`default_nettype wire

>>> rtl/systematic_binary_group_code_encoder_top.sv
// An encode transaction (tuser 0) sends the message through the encode unit,
// and the codeword lands in the output register. An analysis transaction
// (tuser 1) walks every nonzero message of the effective message length
// through the same encode unit, one message per cycle; the input is not ready
// while the walk runs or while an unclaimed result sits in the output register.
// Configuration writes land at once and are meant for an idle block.
// ----------------------------------------------------------------------------
// systematic_binary_group_code_encoder_top
// Systematic binary group code encoder with minimum-weight analysis.
// ----------------------------------------------------------------------------
`default_nettype none

module systematic_binary_group_code_encoder_top #(
    parameter int MAX_MESSAGE_BITS = 8,
    parameter int MAX_PARITY_BITS  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] message
    input  wire logic        i_s_tuser,   // [0] func
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // [15:0] codeword, [19:16] detectable_errors
);

    localparam int MW = MAX_MESSAGE_BITS;
    localparam int LB = sbgc_pkg::LEN_BITS;
    localparam int WB = sbgc_pkg::WT_BITS;
    localparam int DB = sbgc_pkg::DET_BITS;
    localparam int CB = sbgc_pkg::CW_BITS;
    localparam int RB = sbgc_pkg::ROW_BITS;

    sbgc_pkg::t_state           r_state, n_state;
    logic [MW-1:0]              r_msg, n_msg;
    logic [WB-1:0]              r_best, n_best;
    logic                       r_out_valid, n_out_valid;
    logic [CB-1:0]              r_out_cw, n_out_cw;
    logic [DB-1:0]              r_out_det, n_out_det;
    logic [LB-1:0]              r_m_len;
    logic [LB-1:0]              r_r_len;
    logic [RB*RB-1:0]           r_matrix;

    logic [LB-1:0]              w_m;
    logic [LB-1:0]              w_r;
    logic [MW-1:0]              w_last;
    logic [RB-1:0]              w_unit_msg;
    logic                       w_in_acc;
    logic [WB-1:0]              w_best_upd;
    sbgc_pkg::t_enc_res         w_enc;

    // Effective lengths: zero message length counts as one, both saturate
    always_comb begin
        w_m = r_m_len;
        if (w_m == '0) begin
            w_m = LB'(1);
        end
        if (w_m > LB'(MAX_MESSAGE_BITS)) begin
            w_m = LB'(MAX_MESSAGE_BITS);
        end
        w_r = r_r_len;
        if (w_r > LB'(MAX_PARITY_BITS)) begin
            w_r = LB'(MAX_PARITY_BITS);
        end
    end

    assign w_last     = {MW{1'b1}} >> (LB'(MW) - w_m);
    assign w_unit_msg = (r_state == sbgc_pkg::ST_WALK) ? RB'(r_msg) : i_s_tdata;

    sbgc_enc u_enc (
        .i_msg    (w_unit_msg),
        .i_m_len  (w_m),
        .i_r_len  (w_r),
        .i_matrix (r_matrix),
        .o_res    (w_enc)
    );

    assign o_s_tready = (r_state == sbgc_pkg::ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_best_upd = ((w_enc.weight != '0) && (w_enc.weight < r_best)) ?
                        w_enc.weight : r_best;

    always_comb begin
        n_state     = r_state;
        n_msg       = r_msg;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_cw    = r_out_cw;
        n_out_det   = r_out_det;
        case (r_state)
            sbgc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser == sbgc_pkg::FUNC_ANALYZE) begin
                        n_state = sbgc_pkg::ST_WALK;
                        n_msg   = MW'(1);
                        n_best  = WB'(w_m) + WB'(w_r);
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_cw    = w_enc.codeword;
                        n_out_det   = '0;
                    end
                end
            end
            sbgc_pkg::ST_WALK: begin
                n_best = w_best_upd;
                n_msg  = r_msg + MW'(1);
                // last message: publish the minimum weight less one
                if (r_msg == w_last) begin
                    n_state     = sbgc_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_cw    = '0;
                    n_out_det   = DB'(w_best_upd - WB'(1));
                end
            end
            default: begin
                n_state = sbgc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbgc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg     <= n_msg;
        r_best    <= n_best;
        r_out_cw  <= n_out_cw;
        r_out_det <= n_out_det;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_len  <= LB'(3);
            r_r_len  <= LB'(2);
            r_matrix <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbgc_pkg::REG_MESSAGE_LENGTH: r_m_len  <= i_cfg_data[LB-1:0];
                sbgc_pkg::REG_PARITY_LENGTH:  r_r_len  <= i_cfg_data[LB-1:0];
                sbgc_pkg::REG_PARITY_MATRIX:  r_matrix <= i_cfg_data[RB*RB-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(24 - CB - DB)'(0), r_out_det, r_out_cw};

`include "systematic_binary_group_code_encoder_top_defines.svh"

    `SBGC_ASSERT_NEXT(a_analyze_starts_walk,
        w_in_acc && (i_s_tuser == sbgc_pkg::FUNC_ANALYZE),
        r_state == sbgc_pkg::ST_WALK, "analysis transaction did not start a walk")

    `SBGC_ASSERT_NOW(a_walk_output_empty,
        r_state == sbgc_pkg::ST_WALK, !r_out_valid && !o_s_tready,
        "output register busy or input ready during walk")

    `SBGC_ASSERT_NOW(a_one_field_zero,
        o_m_tvalid, (o_m_tdata[15:0] == '0) || (o_m_tdata[19:16] == '0),
        "codeword and detectable count both nonzero")

    `SBGC_ASSERT_NOW(a_walk_in_range,
        r_state == sbgc_pkg::ST_WALK, (r_msg != '0) && (r_msg <= w_last),
        "walk counter out of message range")

endmodule

`default_nettype wire
